[rtl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DEPTH_W = 9;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_val;
    logic signed [DATA_W-1:0] val;
  } entry_t;

endpackage

[rtl/mts_if.sv]
// ----------------------------------------------------------------------------
// mts_in_if / mts_out_if
// Valid/ready channels for stack operations and their results.
// ----------------------------------------------------------------------------
interface mts_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [mts_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface mts_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mts_pkg::DATA_W-1:0]  top_value;
  logic signed [mts_pkg::DATA_W-1:0]  min_value;
  logic                               is_empty;
  logic        [mts_pkg::DEPTH_W-1:0] depth_now;
  logic        [1:0]                  status;

  modport source (output valid, output top_value, output min_value, output is_empty,
                  output depth_now, output status, input ready);
  modport sink (input valid, input top_value, input min_value, input is_empty,
                input depth_now, input status, output ready);
endinterface

[rtl/min_tracking_stack.sv]
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded LIFO of signed values that also reports the running minimum.
// ----------------------------------------------------------------------------
// The result of a transaction is registered and valid in the cycle after it is accepted.
// Throughput: one transaction per cycle if unstalled; the top entry is registered
// and the one below it is prefetched from the single-port-read memory every cycle.
// Reset clears the stack pointer and the result valid flag; the entry memory is not
// cleared and needs no clearing pass, so the block is ready right after reset.
module min_tracking_stack #(
  parameter int unsigned DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  mts_in_if.sink     in_ch,
  mts_out_if.source  out_ch
);

  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [PW-1:0]          sp_r;
  logic [PW-1:0]          sp_nxt;
  mts_pkg::entry_t        top_r;
  mts_pkg::entry_t        top_nxt;
  mts_pkg::entry_t        below_r;
  mts_pkg::entry_t        mem [DEPTH];

  logic                   acc;
  logic                   is_full;
  logic                   is_zero;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  mts_pkg::status_t       status_nxt;
  logic signed [mts_pkg::DATA_W-1:0] min_new;

  logic                              out_valid_r;
  logic signed [mts_pkg::DATA_W-1:0] out_top_r;
  logic signed [mts_pkg::DATA_W-1:0] out_min_r;
  logic                              out_empty_r;
  logic [mts_pkg::DEPTH_W-1:0]       out_depth_r;
  mts_pkg::status_t                  out_status_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_full     = (sp_r == PW'(DEPTH));
  assign is_zero     = (sp_r == '0);
  assign min_new     = (!is_zero && ($signed(top_r.min_val) < $signed(in_ch.value)))
                       ? top_r.min_val : in_ch.value;

  always_comb begin
    sp_nxt     = sp_r;
    top_nxt    = top_r;
    wr_en      = 1'b0;
    status_nxt = mts_pkg::ST_OK;
    if (acc) begin
      if (in_ch.kind == mts_pkg::KIND_PUSH) begin
        if (is_full) begin
          status_nxt = mts_pkg::ST_OVERFLOW;
        end else begin
          sp_nxt          = sp_r + PW'(1);
          top_nxt.val     = in_ch.value;
          top_nxt.min_val = min_new;
          wr_en           = !is_zero;
        end
      end else begin
        if (is_zero) begin
          status_nxt = mts_pkg::ST_UNDERFLOW;
        end else begin
          sp_nxt  = sp_r - PW'(1);
          top_nxt = below_r;
        end
      end
    end
  end

  // The memory holds every entry under the top one; the read port always
  // fetches the entry just under the next top.
  assign wr_addr = AW'(sp_r - PW'(1));
  assign rd_addr = AW'(sp_nxt - PW'(2));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      below_r <= top_r;
    end else begin
      below_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r <= sp_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (acc) begin
      out_top_r    <= (sp_nxt == '0) ? '0 : top_nxt.val;
      out_min_r    <= (sp_nxt == '0) ? '0 : top_nxt.min_val;
      out_empty_r  <= (sp_nxt == '0);
      out_depth_r  <= mts_pkg::DEPTH_W'(sp_nxt);
      out_status_r <= status_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.top_value = out_top_r;
  assign out_ch.min_value = out_min_r;
  assign out_ch.is_empty  = out_empty_r;
  assign out_ch.depth_now = out_depth_r;
  assign out_ch.status    = out_status_r;

  a_sp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(sp_r))
    else $error("Stack pointer moved without a transaction.");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (status_nxt == mts_pkg::ST_OVERFLOW) |=> is_full)
    else $error("Overflow reported while the stack was not full.");

  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    !is_zero |-> ($signed(top_r.min_val) <= $signed(top_r.val)))
    else $error("Tracked minimum exceeds the top value.");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> (out_depth_r == '0) && (out_top_r == '0)
                                   && (out_min_r == '0))
    else $error("Empty result carries nonzero fields.");

endmodule
